>>> rtl/dqne_pkg.sv
// Package for the DNS question-name extractor.
// Holds payload and queue entry types, parse phases, codes and the QTYPE table.
// No dependencies.
package dqne_pkg;

   localparam int MAX_FRAME_BYTES = 2048;
   localparam int OFF_W           = $clog2(MAX_FRAME_BYTES + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // frame offsets, some relative to the IP header length
   localparam logic [OFF_W-1:0] IHL_OFFSET    = OFF_W'(14);
   localparam logic [OFF_W-1:0] ETH_HDR_BYTES = OFF_W'(14);
   localparam logic [OFF_W-1:0] MIN_IP_LEN    = OFF_W'(34);
   localparam logic [OFF_W-1:0] UDP_END_BASE  = OFF_W'(22);
   localparam logic [OFF_W-1:0] FLAGS_BASE    = OFF_W'(24);
   localparam logic [OFF_W-1:0] QD_LAST_HDR   = OFF_W'(33);

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_SEP  = 2'd1;
   localparam logic [1:0] KIND_TYPE = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   localparam logic [2:0] ERR_SHORT_ETH = 3'd0;
   localparam logic [2:0] ERR_SHORT_IP  = 3'd1;
   localparam logic [2:0] ERR_IP_OPTS   = 3'd2;
   localparam logic [2:0] ERR_SHORT_UDP = 3'd3;
   localparam logic [2:0] ERR_TRUNC_DNS = 3'd4;

   localparam logic [3:0] TYPE_OTHER = 4'd15;
   localparam int         NUM_KNOWN  = 15;
   localparam logic [7:0] KNOWN_TYPES [NUM_KNOWN] = '{
      8'd1, 8'd2, 8'd5, 8'd6, 8'd12, 8'd15, 8'd16, 8'd28,
      8'd43, 8'd46, 8'd48, 8'd50, 8'd51, 8'd99, 8'd250
   };

   typedef enum logic [2:0] {
      PH_HEADERS,
      PH_LEN,
      PH_CHARS,
      PH_QHI,
      PH_QLO,
      PH_DONE,
      PH_SILENT
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] name_char;
      logic [7:0] qtype_low;
      logic [3:0] type_index;
      logic [2:0] error_code;
      logic       end_of_record;
   } rsp_item_type;

   typedef struct packed {
      logic       has_main;
      logic [1:0] main_kind;
      logic [7:0] data;
      logic       has_err;
      logic [2:0] err_code;
   } qe_type;

   function automatic logic [3:0] classify(input logic [7:0] v);
      logic [3:0] idx;
      idx = TYPE_OTHER;
      for (int i = NUM_KNOWN - 1; i >= 0; i--) begin
         if (KNOWN_TYPES[i] == v) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/dqne_front.sv
// Front end: walks the frame headers and question name, one byte per cycle while the queue is not full.
// Emits one queue entry per byte that yields results. Uses dqne_pkg.
module dqne_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dqne_pkg::req_item_type req_item,
   output logic                  push,
   output dqne_pkg::qe_type      push_entry,
   input  logic                  queue_full
);

   dqne_pkg::phase_type             phase_ff, phase_cur;
   logic [dqne_pkg::OFF_W-1:0]      off_ff, off_in;
   logic [5:0]                      ihl_ff, ihl_cur;
   logic [7:0]                      lrem_ff, lrem_cur;
   logic                            isq_ff, isq_cur;
   logic                            first_ff, first_cur;
   logic [dqne_pkg::OFF_W-1:0]      ihl_ext;
   logic [dqne_pkg::OFF_W-1:0]      len;
   logic [7:0]                      b;
   logic                            acc;

   assign req_ready = !queue_full;
   assign acc       = req_valid && req_ready;
   assign b         = req_item.data_byte;
   assign ihl_ext   = dqne_pkg::OFF_W'(ihl_cur);
   assign len       = off_ff + dqne_pkg::OFF_W'(1);

   always_comb begin
      phase_cur  = phase_ff;
      ihl_cur    = ihl_ff;
      lrem_cur   = lrem_ff;
      isq_cur    = isq_ff;
      first_cur  = first_ff;
      push_entry = '0;
      if (phase_ff == dqne_pkg::PH_HEADERS && off_ff == dqne_pkg::IHL_OFFSET) begin
         ihl_cur = {b[3:0], 2'b00};
      end
      unique case (phase_ff)
         dqne_pkg::PH_HEADERS: begin
            if (off_ff == dqne_pkg::FLAGS_BASE + ihl_ext) begin
               isq_cur = !b[7];
               if (b[7]) begin
                  phase_cur = dqne_pkg::PH_SILENT;
               end
            end
            if (phase_cur == dqne_pkg::PH_HEADERS
                && off_ff == dqne_pkg::QD_LAST_HDR + ihl_ext) begin
               phase_cur = dqne_pkg::PH_LEN;
            end
         end
         dqne_pkg::PH_LEN: begin
            if (b == 8'd0) begin
               phase_cur = dqne_pkg::PH_QHI;
            end else begin
               if (!first_ff) begin
                  push_entry.has_main  = 1'b1;
                  push_entry.main_kind = dqne_pkg::KIND_SEP;
               end
               first_cur = 1'b0;
               lrem_cur  = b;
               phase_cur = dqne_pkg::PH_CHARS;
            end
         end
         dqne_pkg::PH_CHARS: begin
            push_entry.has_main  = 1'b1;
            push_entry.main_kind = dqne_pkg::KIND_CHAR;
            push_entry.data      = b;
            lrem_cur             = lrem_ff - 8'd1;
            if (lrem_cur == 8'd0) begin
               phase_cur = dqne_pkg::PH_LEN;
            end
         end
         dqne_pkg::PH_QHI: begin
            phase_cur = dqne_pkg::PH_QLO;
         end
         dqne_pkg::PH_QLO: begin
            push_entry.has_main  = 1'b1;
            push_entry.main_kind = dqne_pkg::KIND_TYPE;
            push_entry.data      = b;
            phase_cur            = dqne_pkg::PH_DONE;
         end
         dqne_pkg::PH_DONE, dqne_pkg::PH_SILENT: begin
         end
         default: begin
         end
      endcase

      if (req_item.last_byte) begin
         push_entry.has_err = 1'b1;
         priority if (len < dqne_pkg::ETH_HDR_BYTES) begin
            push_entry.err_code = dqne_pkg::ERR_SHORT_ETH;
         end else if (len < dqne_pkg::MIN_IP_LEN) begin
            push_entry.err_code = dqne_pkg::ERR_SHORT_IP;
         end else if (len < dqne_pkg::ETH_HDR_BYTES + ihl_ext) begin
            push_entry.err_code = dqne_pkg::ERR_IP_OPTS;
         end else if (len < dqne_pkg::UDP_END_BASE + ihl_ext) begin
            push_entry.err_code = dqne_pkg::ERR_SHORT_UDP;
         end else if (len <= dqne_pkg::FLAGS_BASE + ihl_ext) begin
            push_entry.err_code = dqne_pkg::ERR_TRUNC_DNS;
         end else if (isq_cur && phase_cur != dqne_pkg::PH_DONE) begin
            push_entry.err_code = dqne_pkg::ERR_TRUNC_DNS;
         end else begin
            push_entry.has_err = 1'b0;
         end
      end
   end

   assign push = acc && (push_entry.has_main || push_entry.has_err);

   always_comb begin
      off_in = off_ff;
      if (off_ff < dqne_pkg::OFF_W'(dqne_pkg::MAX_FRAME_BYTES)) begin
         off_in = len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dqne_pkg::PH_HEADERS;
         off_ff   <= '0;
         ihl_ff   <= '0;
         lrem_ff  <= '0;
         isq_ff   <= 1'b0;
         first_ff <= 1'b1;
      end else if (acc) begin
         if (req_item.last_byte) begin
            phase_ff <= dqne_pkg::PH_HEADERS;
            off_ff   <= '0;
            ihl_ff   <= '0;
            lrem_ff  <= '0;
            isq_ff   <= 1'b0;
            first_ff <= 1'b1;
         end else begin
            phase_ff <= phase_cur;
            off_ff   <= off_in;
            ihl_ff   <= ihl_cur;
            lrem_ff  <= lrem_cur;
            isq_ff   <= isq_cur;
            first_ff <= first_cur;
         end
      end
   end

endmodule

>>> rtl/dqne_queue.sv
// Short queue of result entries between the front end and the back end.
// Register-based, QUEUE_DEPTH entries. Uses dqne_pkg.
module dqne_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dqne_pkg::qe_type push_entry,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output dqne_pkg::qe_type head_entry
);

   dqne_pkg::qe_type                mem_ff [dqne_pkg::QUEUE_DEPTH];
   logic [dqne_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [dqne_pkg::QPTR_W:0]       count_ff, count_in;

   assign full       = count_ff == (dqne_pkg::QPTR_W + 1)'(dqne_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (dqne_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (dqne_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + dqne_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + dqne_pkg::QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/dqne_back.sv
// Back end: turns each queue entry into one or two result items.
// Formats fields and classifies QTYPE. Uses dqne_pkg.
module dqne_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  dqne_pkg::qe_type       head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dqne_pkg::rsp_item_type rsp_item
);

   logic sub_ff, sub_in;
   logic on_err;
   logic sent;

   assign on_err    = !head_entry.has_main || sub_ff;
   assign rsp_valid = head_valid;
   assign sent      = rsp_valid && rsp_ready;
   assign pop       = sent && (on_err || !head_entry.has_err);

   always_comb begin
      sub_in = sub_ff;
      if (sent) begin
         sub_in = !pop;
      end
   end

   always_comb begin
      rsp_item = '0;
      if (on_err) begin
         rsp_item.kind          = dqne_pkg::KIND_ERR;
         rsp_item.error_code    = head_entry.err_code;
         rsp_item.end_of_record = 1'b1;
      end else begin
         rsp_item.kind = head_entry.main_kind;
         unique case (head_entry.main_kind)
            dqne_pkg::KIND_CHAR: begin
               rsp_item.name_char = head_entry.data;
            end
            dqne_pkg::KIND_SEP: begin
               rsp_item.name_char = dqne_pkg::DOT_CHAR;
            end
            dqne_pkg::KIND_TYPE: begin
               rsp_item.qtype_low     = head_entry.data;
               rsp_item.type_index    = dqne_pkg::classify(head_entry.data);
               rsp_item.end_of_record = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

>>> rtl/dns_query_name_extractor_unit.sv
// DNS question-name extractor, top level. Uses dqne_pkg, dqne_front, dqne_queue, dqne_back.
// Result items are registered in the queue before they are offered.
// Throughput: one frame byte per cycle while the queue is not full; a byte with two
// results (name item plus error) needs a second send, absorbed by the 4-entry queue.
// Reset: synchronous; clears the parse state and empties the queue.
module dns_query_name_extractor_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dqne_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dqne_pkg::rsp_item_type rsp_item
);

   logic             push;
   dqne_pkg::qe_type push_entry;
   logic             queue_full;
   logic             pop;
   logic             head_valid;
   dqne_pkg::qe_type head_entry;

   dqne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   dqne_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   dqne_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

>>> tb/dns_query_name_extractor_unit_tb.sv
// Testbench for dns_query_name_extractor_unit: feeds whole and cut Ethernet frames byte by byte,
// predicts name, separator, QTYPE and error items and checks them in order.
// Depends on dqne_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module dns_query_name_extractor_unit_tb;

   localparam int RANDOM_BYTES = 330;
   localparam int QUIET_BYTES  = 270;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;
   localparam int NUM_CASES    = 25;

   typedef struct packed {
      int         cut;
      logic [3:0] ihl;
      logic       resp;
      int         nlab;
      int         llen;
      logic [7:0] qtype;
      int         tail;
      logic [7:0] fill;
      logic       typed;
      logic [2:0] want_err;
   } case_row_type;

   // cut 0 sends the whole frame; typed rows carry their error item
   localparam case_row_type DIR_CASES [NUM_CASES] = '{
      '{1,  4'd5,  1'b0, 1, 3,   8'd1,   0, 8'h00, 1'b1, dqne_pkg::ERR_SHORT_ETH},
      '{13, 4'd5,  1'b0, 1, 3,   8'd1,   0, 8'hFF, 1'b1, dqne_pkg::ERR_SHORT_ETH},
      '{14, 4'd5,  1'b0, 1, 3,   8'd1,   0, 8'h00, 1'b1, dqne_pkg::ERR_SHORT_IP},
      '{33, 4'd5,  1'b0, 1, 3,   8'd1,   0, 8'hFF, 1'b1, dqne_pkg::ERR_SHORT_IP},
      '{34, 4'd15, 1'b0, 1, 3,   8'd1,   0, 8'h00, 1'b1, dqne_pkg::ERR_IP_OPTS},
      '{73, 4'd15, 1'b0, 1, 3,   8'd1,   0, 8'hFF, 1'b1, dqne_pkg::ERR_IP_OPTS},
      '{74, 4'd15, 1'b0, 1, 3,   8'd1,   0, 8'h00, 1'b1, dqne_pkg::ERR_SHORT_UDP},
      '{81, 4'd15, 1'b0, 1, 3,   8'd1,   0, 8'hFF, 1'b1, dqne_pkg::ERR_SHORT_UDP},
      '{82, 4'd15, 1'b0, 1, 3,   8'd1,   0, 8'h00, 1'b1, dqne_pkg::ERR_TRUNC_DNS},
      '{84, 4'd15, 1'b0, 1, 3,   8'd1,   0, 8'hFF, 1'b1, dqne_pkg::ERR_TRUNC_DNS},
      '{45, 4'd5,  1'b0, 1, 3,   8'd1,   0, 8'hFF, 1'b1, dqne_pkg::ERR_TRUNC_DNS},
      '{45, 4'd5,  1'b1, 1, 3,   8'd1,   0, 8'h00, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd5,  1'b0, 3, 3,   8'd1,   0, 8'h00, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd5,  1'b0, 0, 0,   8'd250, 0, 8'hFF, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd0,  1'b0, 1, 255, 8'd0,   2, 8'h00, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd1,  1'b0, 2, 1,   8'hFF,  0, 8'hFF, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd2,  1'b0, 2, 2,   8'd28,  0, 8'h00, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd3,  1'b0, 1, 4,   8'd99,  1, 8'hFF, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd4,  1'b0, 1, 5,   8'd15,  0, 8'h00, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd5,  1'b1, 2, 3,   8'd1,   5, 8'h00, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{57, 4'd5,  1'b0, 2, 3,   8'd1,   0, 8'hFF, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{59, 4'd5,  1'b0, 2, 3,   8'd1,   0, 8'h00, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{64, 4'd5,  1'b0, 2, 3,   8'd1,   0, 8'hFF, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd5,  1'b0, 1, 3,   8'd16,  4, 8'hFF, 1'b0, dqne_pkg::ERR_SHORT_ETH},
      '{0,  4'd15, 1'b0, 1, 1,   8'd6,   0, 8'hFF, 1'b0, dqne_pkg::ERR_SHORT_ETH}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   dqne_pkg::req_item_type req_item;
   logic                   rsp_valid;
   logic                   rsp_ready;
   dqne_pkg::rsp_item_type rsp_item;

   dqne_pkg::phase_type cur_phase;
   int                  cur_offset;
   int                  ip_bytes;
   logic [7:0]          label_left;
   logic                in_query;
   logic                first_lbl;

   dqne_pkg::rsp_item_type pending_results[$];
   dqne_pkg::rsp_item_type byte_results[$];
   logic [7:0]             frame_bytes[$];

   int idle_pct     = 0;
   int mismatches   = 0;
   int quiet_cycles = 0;
   int stall_left   = 0;

   dns_query_name_extractor_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [3:0] qtype_slot(input logic [7:0] v);
      for (int i = 0; i < dqne_pkg::NUM_KNOWN; i++) begin
         if (dqne_pkg::KNOWN_TYPES[i] == v) begin
            return 4'(i);
         end
      end
      return dqne_pkg::TYPE_OTHER;
   endfunction

   function automatic void clear_parse();
      cur_phase  = dqne_pkg::PH_HEADERS;
      cur_offset = 0;
      ip_bytes   = 0;
      label_left = 8'd0;
      in_query   = 1'b0;
      first_lbl  = 1'b1;
   endfunction

   function automatic void add_result(input logic [1:0] k, input logic [7:0] ch,
                                      input logic [7:0] ql, input logic [3:0] ti,
                                      input logic [2:0] ec, input logic eor);
      dqne_pkg::rsp_item_type r;
      r = '{k, ch, ql, ti, ec, eor};
      byte_results.push_back(r);
   endfunction

   // advances the parse by one byte and leaves its items in byte_results
   function automatic void parse_byte(input dqne_pkg::req_item_type it);
      int         flen;
      logic [2:0] ec;
      logic       fault;
      byte_results.delete();
      flen = cur_offset + 1;
      case (cur_phase)
         dqne_pkg::PH_HEADERS: begin
            if (cur_offset == int'(dqne_pkg::IHL_OFFSET)) begin
               ip_bytes = int'(it.data_byte[3:0]) * 4;
            end
            if (cur_offset == int'(dqne_pkg::FLAGS_BASE) + ip_bytes) begin
               in_query = !it.data_byte[7];
               if (!in_query) begin
                  cur_phase = dqne_pkg::PH_SILENT;
               end
            end
            if (cur_phase == dqne_pkg::PH_HEADERS
                && cur_offset == int'(dqne_pkg::QD_LAST_HDR) + ip_bytes) begin
               cur_phase = dqne_pkg::PH_LEN;
            end
         end
         dqne_pkg::PH_LEN: begin
            if (it.data_byte == 8'd0) begin
               cur_phase = dqne_pkg::PH_QHI;
            end else begin
               if (!first_lbl) begin
                  add_result(dqne_pkg::KIND_SEP, dqne_pkg::DOT_CHAR, 8'd0, 4'd0, 3'd0, 1'b0);
               end
               first_lbl  = 1'b0;
               label_left = it.data_byte;
               cur_phase  = dqne_pkg::PH_CHARS;
            end
         end
         dqne_pkg::PH_CHARS: begin
            add_result(dqne_pkg::KIND_CHAR, it.data_byte, 8'd0, 4'd0, 3'd0, 1'b0);
            label_left--;
            if (label_left == 8'd0) begin
               cur_phase = dqne_pkg::PH_LEN;
            end
         end
         dqne_pkg::PH_QHI: begin
            cur_phase = dqne_pkg::PH_QLO;
         end
         dqne_pkg::PH_QLO: begin
            add_result(dqne_pkg::KIND_TYPE, 8'd0, it.data_byte, qtype_slot(it.data_byte),
                       3'd0, 1'b1);
            cur_phase = dqne_pkg::PH_DONE;
         end
         default: begin
         end
      endcase
      if (cur_offset < dqne_pkg::MAX_FRAME_BYTES) begin
         cur_offset++;
      end
      if (it.last_byte) begin
         fault = 1'b1;
         ec    = dqne_pkg::ERR_SHORT_ETH;
         if (flen < int'(dqne_pkg::ETH_HDR_BYTES)) begin
            ec = dqne_pkg::ERR_SHORT_ETH;
         end else if (flen < int'(dqne_pkg::MIN_IP_LEN)) begin
            ec = dqne_pkg::ERR_SHORT_IP;
         end else if (flen < int'(dqne_pkg::ETH_HDR_BYTES) + ip_bytes) begin
            ec = dqne_pkg::ERR_IP_OPTS;
         end else if (flen < int'(dqne_pkg::UDP_END_BASE) + ip_bytes) begin
            ec = dqne_pkg::ERR_SHORT_UDP;
         end else if (flen <= int'(dqne_pkg::FLAGS_BASE) + ip_bytes) begin
            ec = dqne_pkg::ERR_TRUNC_DNS;
         end else if (in_query && cur_phase != dqne_pkg::PH_DONE) begin
            ec = dqne_pkg::ERR_TRUNC_DNS;
         end else begin
            fault = 1'b0;
         end
         if (fault) begin
            add_result(dqne_pkg::KIND_ERR, 8'd0, 8'd0, 4'd0, ec, 1'b1);
         end
         clear_parse();
      end
   endfunction

   function automatic void check_field(input string fld, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, fld, want, got);
      end
   endfunction

   task automatic build_frame(input logic [3:0] ihl, input logic resp, input int nlab,
                              input int llen, input logic [7:0] qtype, input int tail,
                              input int fill);
      int         hdr_len;
      int         n;
      logic [7:0] b;
      hdr_len = int'(dqne_pkg::MIN_IP_LEN) + 4 * int'(ihl);
      frame_bytes.delete();
      for (int i = 0; i < hdr_len; i++) begin
         b = (fill < 0) ? 8'($urandom) : 8'(fill);
         if (i == int'(dqne_pkg::IHL_OFFSET)) begin
            b[3:0] = ihl;
         end
         if (i == int'(dqne_pkg::FLAGS_BASE) + 4 * int'(ihl)) begin
            b[7] = resp;
         end
         frame_bytes.push_back(b);
      end
      for (int l = 0; l < nlab; l++) begin
         n = (llen > 0) ? llen : int'($urandom_range(1, 12));
         frame_bytes.push_back(8'(n));
         repeat (n) frame_bytes.push_back(8'($urandom));
      end
      frame_bytes.push_back(8'd0);
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(qtype);
      repeat (tail) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic send_frame(input int cut, input logic typed, input logic [2:0] want_err,
                             output int sent);
      dqne_pkg::req_item_type it;
      dqne_pkg::rsp_item_type r;
      int                     gap;
      sent = (cut > 0) ? cut : frame_bytes.size();
      for (int i = 0; i < sent; i++) begin
         if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            req_valid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clock);
         end
         it.data_byte = frame_bytes[i];
         it.last_byte = (i == sent - 1);
         req_valid    = 1'b1;
         req_item     = it;
         do @(posedge clock); while (!req_ready);
         parse_byte(it);
         if (!typed) begin
            foreach (byte_results[k]) pending_results.push_back(byte_results[k]);
         end else if (it.last_byte) begin
            r = '{dqne_pkg::KIND_ERR, 8'd0, 8'd0, 4'd0, want_err, 1'b1};
            pending_results.push_back(r);
         end
         @(negedge clock);
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(0, 5);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      dqne_pkg::rsp_item_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item, expected none actual %p", $time, rsp_item);
         end else begin
            w = pending_results.pop_front();
            check_field("kind", 8'(w.kind), 8'(rsp_item.kind));
            check_field("name_char", w.name_char, rsp_item.name_char);
            check_field("qtype_low", w.qtype_low, rsp_item.qtype_low);
            check_field("type_index", 8'(w.type_index), 8'(rsp_item.type_index));
            check_field("error_code", 8'(w.error_code), 8'(rsp_item.error_code));
            check_field("end_of_record", 8'(w.end_of_record), 8'(rsp_item.end_of_record));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int         sent;
      int         rnd_sent;
      int         cut;
      int         nlab;
      int         llen;
      int         tail;
      logic [3:0] ihl;
      logic       resp;
      logic [7:0] qtype;
      logic       paused;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      clear_parse();
      repeat (3) @(negedge clock);
      reset = 1'b0;

      idle_pct = 25;
      foreach (DIR_CASES[c]) begin
         build_frame(DIR_CASES[c].ihl, DIR_CASES[c].resp, DIR_CASES[c].nlab,
                     DIR_CASES[c].llen, DIR_CASES[c].qtype, DIR_CASES[c].tail,
                     int'(DIR_CASES[c].fill));
         send_frame(DIR_CASES[c].cut, DIR_CASES[c].typed, DIR_CASES[c].want_err, sent);
      end
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);

      rnd_sent = 0;
      paused   = 1'b0;
      while (rnd_sent < RANDOM_BYTES) begin
         if (rnd_sent >= QUIET_BYTES) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               default: idle_pct = 40;
            endcase
         end
         if (!paused && rnd_sent >= RANDOM_BYTES / 2) begin
            paused    = 1'b1;
            req_valid = 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         ihl   = ($urandom_range(0, 4) != 0) ? 4'd5 : 4'($urandom_range(0, 15));
         resp  = ($urandom_range(0, 9) == 0);
         nlab  = int'($urandom_range(0, 4));
         llen  = ($urandom_range(0, 19) == 0) ? int'($urandom_range(13, 255)) : 0;
         qtype = $urandom_range(0, 1)
                 ? dqne_pkg::KNOWN_TYPES[$urandom_range(0, dqne_pkg::NUM_KNOWN - 1)]
                 : 8'($urandom);
         tail  = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 4));
         build_frame(ihl, resp, nlab, llen, qtype, tail, -1);
         cut = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, frame_bytes.size())) : 0;
         send_frame(cut, 1'b0, dqne_pkg::ERR_SHORT_ETH, sent);
         rnd_sent += sent;
      end

      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/dqne_pkg.sv
rtl/dqne_front.sv
rtl/dqne_queue.sv
rtl/dqne_back.sv
rtl/dns_query_name_extractor_unit.sv
tb/dns_query_name_extractor_unit_tb.sv
